// ===== hdl/pfwp_pkg.sv =====
// Package: payload types, command codes and reset words for the frequency word programmer.
`timescale 1ns / 1ps
package pfwp_pkg;

    localparam int NumWords = 6;
    localparam int FvcoW    = 40;

    typedef enum logic [1:0] {
        REQ_SET_FREQ = 2'd0,
        REQ_SET_POWER = 2'd1,
        REQ_REWRITE  = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_code_t;

    localparam logic [0:0] CFG_PFD = 1'b0;
    localparam logic [0:0] CFG_MOD = 1'b1;

    localparam logic [32:0] VcoMinHz  = 33'd3000000000;
    localparam logic [27:0] PfdReset  = 28'd50000000;
    localparam logic [11:0] ModReset  = 12'd4095;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [32:0] out_freq;
        logic [1:0]  power_level;
        logic [1:0]  jitter;
    } in_item_t;

    typedef struct packed {
        logic [31:0] reg_word;
        logic [2:0]  reg_index;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start divider scan
        logic div_step;  // one restoring step
        logic frac_mul;  // remainder times modulus
        logic frac_set;  // start second division
        logic commit;    // write shadow words
        logic emit;      // load output register with current index
        logic next_idx;
    } cmd_t;

    typedef struct packed {
        logic sel_done;
        logic div_done;
        logic idx_zero;
    } stat_t;

    function automatic logic [31:0] reset_word(input logic [2:0] i);
        case (i)
            3'd0: reset_word = 32'h00400000;
            3'd1: reset_word = 32'h08008011;
            3'd2: reset_word = 32'h00004E42;
            3'd3: reset_word = 32'h000004B3;
            3'd4: reset_word = 32'h0080003C;
            3'd5: reset_word = 32'h00580005;
            default: reset_word = 32'h0;
        endcase
    endfunction

endpackage

// ===== hdl/pfwp_datapath.sv =====
// Datapath: divider selection, restoring divider, fraction scaling and shadow words.
`timescale 1ns / 1ps
module pfwp_datapath
    import pfwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  in_item_t    item,
    input  logic [27:0] pfd_freq_hz,
    input  logic [11:0] modulus,
    output out_item_t   out_item
);

    logic [31:0]       words_reg [NumWords];
    logic [31:0]       words_next [NumWords];
    logic [1:0]        req_reg;
    logic [1:0]        pwr_reg;
    logic [1:0]        jit_reg;
    logic [FvcoW-1:0]  fvco_reg;
    logic [2:0]        sel_reg;
    logic [FvcoW-1:0]  quo_reg;
    logic [27:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic [31:0]       ipart_reg;
    logic [2:0]        idx_reg;
    logic [27:0]       pfd;
    logic [28:0]       trial;
    logic              fits;
    logic [11:0]       frac;
    logic [31:0]       frac_j;

    assign pfd   = (pfd_freq_hz == 28'd0) ? 28'd1 : pfd_freq_hz;
    assign trial = {rem_reg, quo_reg[FvcoW-1]};
    assign fits  = trial >= {1'b0, pfd};

    assign stat.sel_done = (sel_reg == 3'd6) || (fvco_reg >= {7'd0, VcoMinHz});
    assign stat.div_done = (cnt_reg == 6'd0);
    assign stat.idx_zero = (idx_reg == 3'd0);

    assign frac   = quo_reg[11:0];
    assign frac_j = ((frac == 12'd0) ? 32'd1 : {20'd0, frac}) + {30'd0, jit_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= item.req_type;
            pwr_reg  <= item.power_level;
            jit_reg  <= item.jitter;
            fvco_reg <= {7'd0, item.out_freq};
            sel_reg  <= 3'd0;
        end
        else if (!stat.sel_done && cnt_reg == 6'd63)
        begin
            fvco_reg <= fvco_reg << 1;
            sel_reg  <= sel_reg + 3'd1;
        end
        if (cmd.load)
        begin
            cnt_reg <= 6'd63;
        end
        else if (cnt_reg == 6'd63 && stat.sel_done && req_reg == REQ_SET_FREQ)
        begin
            quo_reg <= fvco_reg;
            rem_reg <= 28'd0;
            cnt_reg <= 6'(FvcoW);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[FvcoW-2:0], fits};
            rem_reg <= fits ? 28'(trial - {1'b0, pfd}) : trial[27:0];
            cnt_reg <= cnt_reg - 6'd1;
        end
        else if (cmd.frac_mul)
        begin
            ipart_reg <= quo_reg[31:0];
            quo_reg   <= {12'd0, rem_reg} * {28'd0, modulus};
            rem_reg   <= 28'd0;
        end
        else if (cmd.frac_set)
        begin
            cnt_reg <= 6'(FvcoW);
        end
        if (cmd.load) idx_reg <= 3'd5;
        else if (cmd.next_idx) idx_reg <= idx_reg - 3'd1;
        if (cmd.emit)
        begin
            out_item.reg_word  <= words_reg[idx_reg];
            out_item.reg_index <= idx_reg;
            out_item.last      <= (idx_reg == 3'd0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NumWords; i++) words_next[i] = words_reg[i];
        if (req_reg == REQ_SET_FREQ)
        begin
            words_next[0] = (ipart_reg << 15) | (frac_j << 3);
            words_next[1][14:3] = modulus;
            words_next[4][22:20] = sel_reg;
        end
        else if (req_reg == REQ_SET_POWER)
        begin
            words_next[4][4:3] = pwr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++) words_reg[i] <= reset_word(3'(i));
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < NumWords; i++) words_reg[i] <= words_next[i];
        end
    end

endmodule

// ===== hdl/pfwp_ctrl.sv =====
// Controller: sequences selection, two divisions for set frequency, commit and the six-word run.
`timescale 1ns / 1ps
module pfwp_ctrl
    import pfwp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic [1:0] in_req,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SEL   = 8'b00000010,
        S_DIV1  = 8'b00000100,
        S_MUL   = 8'b00001000,
        S_DIV2  = 8'b00010000,
        S_COMMIT= 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   is_freq_reg, is_freq_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        is_freq_next   = is_freq_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    is_freq_next = (in_req == REQ_SET_FREQ);
                    if (in_req != REQ_UNUSED) state_next = S_SEL;
                end
            end
            S_SEL: begin
                if (stat.sel_done) state_next = is_freq_reg ? S_DIV1 : S_COMMIT;
            end
            S_DIV1: begin
                if (stat.div_done) state_next = S_MUL;
                else cmd.div_step = 1'b1;
            end
            S_MUL: begin
                cmd.frac_mul = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2: begin
                if (!cmd.frac_set && stat.div_done && is_freq_reg) begin
                    cmd.frac_set = 1'b1;
                    is_freq_next = 1'b0;
                end else if (stat.div_done) state_next = S_COMMIT;
                else cmd.div_step = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_stall) begin
                    if (stat.idx_zero) begin
                        out_valid_next = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_idx = 1'b1;
                        out_valid_next = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            is_freq_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            is_freq_reg   <= is_freq_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/pll_frequency_word_programmer.sv =====
// Top level of the frequency word programmer.
// Set frequency: from acceptance to the first word the controller runs selection, two 40-step
// restoring divisions with their set-up states, then commit.
// Set power and rewrite skip the divisions; each word then waits in S_OUT while stalled.
// One request at a time: a new request is taken only after the last word is out.
// Reset: asynchronous active low; restores the six default words and both registers.
`timescale 1ns / 1ps
module pll_frequency_word_programmer
    import pfwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t        cmd;
    stat_t       stat;
    logic [27:0] pfd_reg;
    logic [11:0] mod_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfd_reg <= PfdReset;
            mod_reg <= ModReset;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PFD) pfd_reg <= cfg_data[27:0];
            else mod_reg <= cfg_data[11:0];
        end
    end

    pfwp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_req    (in_data.req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfwp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item        (in_data),
        .pfd_freq_hz (pfd_reg),
        .modulus     (mod_reg),
        .out_item    (out_data)
    );

endmodule

// ===== hdl/pfwp_checker.sv =====
// Port checker for the frequency word programmer, bound to the top level.
`timescale 1ns / 1ps
module pfwp_checker
    import pfwp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during word run");

    a_last_idx0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.reg_index == 3'd0)))
        else $error("last flag mismatch");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.reg_index <= 3'd5) else $error("bad index");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled word changed");

endmodule

bind pll_frequency_word_programmer pfwp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== bench/pll_frequency_word_programmer_tb.sv =====
// Testbench: frequency word programmer checked against an in-bench predictor of the shadow words.
`timescale 1ns / 1ps
module pll_frequency_word_programmer_tb
    import pfwp_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] shadow_model [NumWords];
    logic [27:0] pfd_model;
    logic [11:0] mod_model;
    out_item_t   word_queue [$];
    int          mismatches;
    int          cycle_count;
    int          stall_left;

    localparam int CycleLimit = 400000;

    pll_frequency_word_programmer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Update the shadow copy for one request and queue the six words it emits; an unused code emits none.
    task automatic predict_words(input in_item_t req);
        logic [2:0]  sel;
        logic [39:0] fvco;
        logic [39:0] pfd;
        logic [39:0] quot;
        logic [39:0] rem;
        logic [63:0] frac_wide;
        logic [31:0] frac;
        out_item_t   w;
        begin
            case (req.req_type)
                REQ_SET_FREQ:
                begin
                    sel = 3'd0;
                    fvco = {7'd0, req.out_freq};
                    while (sel < 3'd6 && fvco < 40'd3000000000)
                    begin
                        fvco = fvco << 1;
                        sel++;
                    end
                    pfd = (pfd_model == 0) ? 40'd1 : {12'd0, pfd_model};
                    quot = fvco / pfd;
                    rem = fvco % pfd;
                    frac_wide = ({24'd0, rem} * mod_model) / pfd;
                    frac = frac_wide[31:0];
                    if (frac == 0)
                        frac = 32'd1;
                    frac = frac + req.jitter;
                    shadow_model[0] = (quot[31:0] << 15) | (frac << 3);
                    shadow_model[1][14:3] = mod_model;
                    shadow_model[4][22:20] = sel;
                end
                REQ_SET_POWER: shadow_model[4][4:3] = req.power_level;
                REQ_REWRITE: ;
                default: return;
            endcase
            for (int i = NumWords - 1; i >= 0; i--)
            begin
                w.reg_word = shadow_model[i];
                w.reg_index = i[2:0];
                w.last = (i == 0);
                word_queue.push_back(w);
            end
        end
    endtask

    // Valid stays high after acceptance so that a request with no gap follows at once.
    task automatic send_request(input in_item_t req);
        int gap;
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= req;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            predict_words(req);
        end
    endtask

    // Drop valid after the last request of a burst.
    task automatic drop_request();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        begin
            drop_request();
            while (word_queue.size() != 0) @(posedge clk);
            repeat (120) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            @(posedge clk);
            if (idx == CFG_PFD)
                pfd_model = value[27:0];
            else
                mod_model = value[11:0];
        end
    endtask

    function automatic in_item_t make_request(input req_code_t code, input logic [32:0] freq,
                                              input logic [1:0] pwr, input logic [1:0] jit);
        in_item_t r;
        r.req_type = code;
        r.out_freq = freq;
        r.power_level = pwr;
        r.jitter = jit;
        return r;
    endfunction

    function automatic logic [32:0] random_freq();
        case ($urandom_range(0, 5))
            0: return 33'($urandom_range(0, 1000));
            1: return {1'b0, $urandom};
            2: return {1'($urandom_range(0, 1)), $urandom};
            3: return 33'd6000000000 - $urandom_range(0, 100000);
            default: return 33'($urandom_range(23000000, 2147483647)) * 2;
        endcase
    endfunction

    function automatic in_item_t random_request();
        int pick;
        req_code_t code;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            code = REQ_SET_FREQ;
        else if (pick < 16)
            code = REQ_SET_POWER;
        else if (pick < 19)
            code = REQ_REWRITE;
        else
            code = REQ_UNUSED;
        return make_request(code, random_freq(), 2'($urandom), 2'($urandom));
    endfunction

    task automatic test_directed();
        begin
            send_request(make_request(REQ_REWRITE, 33'd0, 2'd0, 2'd0));
            send_request(make_request(REQ_SET_FREQ, 33'd0, 2'd3, 2'd3));
            send_request(make_request(REQ_SET_FREQ, 33'h1FFFFFFFF, 2'd0, 2'd0));
            send_request(make_request(REQ_SET_FREQ, 33'd6000000000, 2'd1, 2'd1));
            send_request(make_request(REQ_SET_FREQ, 33'd3000000000, 2'd0, 2'd2));
            send_request(make_request(REQ_SET_FREQ, 33'd2999999999, 2'd0, 2'd0));
            send_request(make_request(REQ_SET_FREQ, 33'd46875000, 2'd0, 2'd0));
            send_request(make_request(REQ_SET_FREQ, 33'd46874999, 2'd0, 2'd3));
            send_request(make_request(REQ_SET_FREQ, 33'd1, 2'd0, 2'd1));
            send_request(make_request(REQ_SET_POWER, 33'd0, 2'd3, 2'd0));
            send_request(make_request(REQ_SET_POWER, 33'h1FFFFFFFF, 2'd0, 2'd3));
            send_request(make_request(REQ_UNUSED, 33'h1FFFFFFFF, 2'd3, 2'd3));
            send_request(make_request(REQ_SET_POWER, 33'd0, 2'd2, 2'd0));
            send_request(make_request(REQ_REWRITE, 33'h1FFFFFFFF, 2'd3, 2'd3));
        end
    endtask

    // Drive six settings, the extremes and a zero divisor among them.
    task automatic test_settings();
        logic [31:0] pfds [6];
        logic [31:0] mods [6];
        begin
            pfds = '{32'd1, 32'd140000000, 32'd0, 32'hFFFFFFFF, 32'd10000000, 32'd50000000};
            mods = '{32'd2, 32'd4095, 32'd4095, 32'hFFFFF001, 32'd1000, 32'd4095};
            for (int s = 0; s < 6; s++)
            begin
                wait_idle();
                write_register(CFG_PFD, pfds[s]);
                write_register(CFG_MOD, mods[s]);
                send_request(make_request(REQ_SET_FREQ, 33'd6000000000, 2'd0, 2'd3));
                send_request(make_request(REQ_SET_FREQ, 33'd0, 2'd0, 2'd0));
                send_request(make_request(REQ_SET_FREQ, 33'd123456789, 2'd0, 2'd1));
                for (int i = 0; i < 10; i++)
                    send_request(random_request());
            end
        end
    endtask

    task automatic test_random();
        begin
            wait_idle();
            write_register(CFG_PFD, 32'($urandom_range(1, 140000000)));
            write_register(CFG_MOD, 32'($urandom_range(2, 4095)));
            for (int i = 0; i < 300; i++)
            begin
                send_request(random_request());
                // hold off until all words are out, once in a while
                if (i % 97 == 50)
                begin
                    drop_request();
                    while (word_queue.size() != 0) @(posedge clk);
                end
                if (i % 100 == 99)
                begin
                    wait_idle();
                    write_register(CFG_PFD, 32'($urandom));
                    write_register(CFG_MOD, 32'($urandom));
                end
            end
        end
    endtask

    // Hold off each word for a drawn number of cycles, with calm stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if ((cycle_count / 2000) % 4 == 3)
                stall_left = 0;
            else
                stall_left = $urandom_range(0, 5);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (word_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h index %0d", out_data.reg_word,
                             out_data.reg_index);
            end
            else
            begin
                exp_word = word_queue.pop_front();
                if (exp_word !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                 exp_word.reg_word, exp_word.reg_index, exp_word.last,
                                 out_data.reg_word, out_data.reg_index, out_data.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PFD;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        for (int i = 0; i < NumWords; i++)
            shadow_model[i] = reset_word(i[2:0]);
        pfd_model = PfdReset;
        mod_model = ModReset;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_random();
        wait_idle();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
